/* rtl/tdfp_pkg.sv */
// shared types, constants and helpers for the tagged decimal frame parser
// no dependencies; imported by every module of the block

package tdfp_pkg;

    // width of one collected decimal value and of each result field
    localparam int VALUE_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int FIELD_COUNT = 5;
    localparam int IDX_WIDTH   = $clog2(FIELD_COUNT);
    localparam int BYTE_WIDTH  = 8;
    localparam int OUT_DATA_WIDTH = FIELD_COUNT * OUT_WIDTH;

    typedef logic [IDX_WIDTH-1:0]          t_field_idx;
    typedef logic [BYTE_WIDTH-1:0]         t_byte;
    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    localparam t_field_idx FIELD_LAST = t_field_idx'(FIELD_COUNT - 1);

    // frame characters
    localparam t_byte CH_HEAD  = 8'h48;  // H
    localparam t_byte CH_TAIL  = 8'h54;  // T
    localparam t_byte CH_SEP_A = 8'h61;  // a
    localparam t_byte CH_SEP_B = 8'h62;  // b
    localparam t_byte CH_SEP_C = 8'h63;  // c
    localparam t_byte CH_SEP_D = 8'h64;  // d
    localparam t_byte CH_MINUS = 8'h2d;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_NINE  = 8'h39;
    localparam t_byte CH_TAB   = 8'h09;  // first of tab, lf, vt, ff, cr
    localparam t_byte CH_CR    = 8'h0d;

    // per-field capture state
    typedef struct packed {
        t_value acc;
        logic   digit_seen;
        logic   digits_ended;
        logic   negative_sign;
    } t_field_state;

    localparam t_field_state FIELD_CLEAR = '{
        acc: '0, digit_seen: 1'b0, digits_ended: 1'b0, negative_sign: 1'b0};

    // separator that closes a given field
    function automatic t_byte separator_for(input t_field_idx idx);
        t_byte sep;
        case (idx)
            t_field_idx'(0): sep = CH_SEP_A;
            t_field_idx'(1): sep = CH_SEP_B;
            t_field_idx'(2): sep = CH_SEP_C;
            t_field_idx'(3): sep = CH_SEP_D;
            default:         sep = CH_TAIL;
        endcase
        return sep;
    endfunction

    // sign extension of a value to the result field width
    function automatic logic [OUT_WIDTH-1:0] widen(input t_value v);
        return OUT_WIDTH'(v);
    endfunction

endpackage

/* rtl/tdfp_digit_acc.sv */
// content update of one field: white space, minus sign, saturating decimal digits
// depends on tdfp_pkg

module tdfp_digit_acc
    import tdfp_pkg::*;
(
    input  t_field_state i_field,
    input  t_byte        i_byte,
    output t_field_state o_field
);

    localparam int WIDE = VALUE_WIDTH + 5;

    localparam logic [VALUE_WIDTH-1:0] MAX_BITS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] MIN_BITS = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [WIDE-1:0] WIDE_MAX = WIDE'(signed'(MAX_BITS));
    localparam logic signed [WIDE-1:0] WIDE_MIN = WIDE'(signed'(MIN_BITS));

    logic                   is_digit;
    logic                   is_blank;
    logic signed [WIDE-1:0] acc_ext;
    logic signed [WIDE-1:0] acc_x10;
    logic signed [WIDE-1:0] digit_ext;
    logic signed [WIDE-1:0] sum;
    t_value                 sat;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign is_blank = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));

    // times ten as two shifts and an add, then digit in or out by sign
    assign acc_ext   = WIDE'(i_field.acc);
    assign acc_x10   = (acc_ext <<< 3) + (acc_ext <<< 1);
    assign digit_ext = signed'(WIDE'(i_byte - CH_ZERO));
    assign sum       = i_field.negative_sign ? (acc_x10 - digit_ext) : (acc_x10 + digit_ext);

    // clamp to the signed value range
    always_comb begin
        if (sum > WIDE_MAX) begin
            sat = t_value'(WIDE_MAX);
        end else if (sum < WIDE_MIN) begin
            sat = t_value'(WIDE_MIN);
        end else begin
            sat = t_value'(sum);
        end
    end

    // capture decision for this word
    always_comb begin
        o_field = i_field;
        if (!i_field.digits_ended) begin
            if (is_digit) begin
                o_field.digit_seen = 1'b1;
                o_field.acc        = sat;
            end else if (!i_field.digit_seen && !i_field.negative_sign && is_blank) begin
                o_field = i_field;
            end else if (!i_field.digit_seen && !i_field.negative_sign &&
                         (i_byte == CH_MINUS)) begin
                o_field.negative_sign = 1'b1;
            end else begin
                o_field.digits_ended = 1'b1;
            end
        end
    end

endmodule

/* rtl/tdfp_frame_ctrl.sv */
// frame tracking: head, separators, tail, held values per field
// depends on tdfp_pkg and tdfp_digit_acc

module tdfp_frame_ctrl
    import tdfp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  t_byte                     i_byte,
    output logic                      o_emit,
    output logic [OUT_DATA_WIDTH-1:0] o_values
);

    logic         r_in_frame;
    logic         n_in_frame;
    t_field_idx   r_field_idx;
    t_field_idx   n_field_idx;
    t_field_state r_field;
    t_field_state n_field;
    t_value       r_held [FIELD_COUNT];
    t_value       n_held [FIELD_COUNT];
    t_field_state content_field;
    logic         is_sep;

    tdfp_digit_acc u_digit_acc (
        .i_field (r_field),
        .i_byte  (i_byte),
        .o_field (content_field)
    );

    assign is_sep = (i_byte == separator_for(r_field_idx));

    // next frame state for the byte at the input register
    always_comb begin
        n_in_frame  = r_in_frame;
        n_field_idx = r_field_idx;
        n_field     = r_field;
        n_held      = r_held;
        o_emit      = 1'b0;
        if (!r_in_frame) begin
            if (i_byte == CH_HEAD) begin
                n_in_frame  = 1'b1;
                n_field_idx = '0;
                n_field     = FIELD_CLEAR;
            end
        end else if (i_byte == CH_HEAD) begin
            n_in_frame = r_in_frame;
        end else if (is_sep) begin
            if (r_field.digit_seen) begin
                n_held[r_field_idx] = r_field.acc;
            end
            n_field = FIELD_CLEAR;
            if (r_field_idx == FIELD_LAST) begin
                n_in_frame  = 1'b0;
                n_field_idx = '0;
                o_emit      = 1'b1;
            end else begin
                n_field_idx = t_field_idx'(r_field_idx + 1'b1);
            end
        end else if (i_byte == CH_TAIL) begin
            n_in_frame  = 1'b0;
            n_field_idx = '0;
            n_field     = FIELD_CLEAR;
        end else begin
            n_field = content_field;
        end
    end

    // result words, field one in the lowest bits
    always_comb begin
        for (int i = 0; i < FIELD_COUNT; i++) begin
            o_values[i*OUT_WIDTH +: OUT_WIDTH] = widen(n_held[i]);
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_field_idx <= '0;
            r_field     <= FIELD_CLEAR;
            for (int i = 0; i < FIELD_COUNT; i++) begin
                r_held[i] <= '0;
            end
        end else if (i_step) begin
            r_in_frame  <= n_in_frame;
            r_field_idx <= n_field_idx;
            r_field     <= n_field;
            r_held      <= n_held;
        end
    end

    // field index stays within the five fields
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field_idx <= FIELD_LAST)
        else $error("field index out of range");

    // outside a frame the field state is clean and the index is at the start
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_field_idx == '0) && (r_field == FIELD_CLEAR))
        else $error("stale field state outside a frame");

    // a result only closes the last field of an open frame
    a_emit_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> r_in_frame && (r_field_idx == FIELD_LAST) && (i_byte == CH_TAIL))
        else $error("result outside the last field");

    // a stepped completion leaves the frame
    a_emit_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_emit) |=> !r_in_frame)
        else $error("frame still open after completion");

endmodule

/* rtl/tagged_decimal_frame_parser.sv */
// A result for the word holding the tail T passes through the input register, then
// the result register, onto o_m_axis_tdata.
// Throughput: one byte per cycle; a completing byte waits in the input register only
// while the previous result is still held and not taken.
// Reset: i_rst_n synchronous, active low; clears frame state, held values to zero, valids.
// depends on tdfp_pkg and tdfp_frame_ctrl

module tagged_decimal_frame_parser
    import tdfp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [BYTE_WIDTH-1:0]     i_s_axis_tdata,   // [7:0] rx_byte
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // [31:0] value_one, [63:32] value_two, [95:64] value_three,
    // [127:96] value_four, [159:128] value_five
    output logic [OUT_DATA_WIDTH-1:0] o_m_axis_tdata
);

    logic                      r_in_valid;
    t_byte                     r_in_byte;
    logic                      r_out_valid;
    logic [OUT_DATA_WIDTH-1:0] r_out_data;
    logic                      emit;
    logic                      step;
    logic [OUT_DATA_WIDTH-1:0] values;

    tdfp_frame_ctrl u_frame_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_emit   (emit),
        .o_values (values)
    );

    // the held word moves on unless it completes a frame while the result register is full and not taken
    assign step            = r_in_valid && (!emit || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_data <= values;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

/* verif/tb_tagged_decimal_frame_parser.sv */
// self-checking testbench for tagged_decimal_frame_parser: byte stream in, five-value frames out
// depends on tdfp_pkg and the rtl of the parser; a built-in frame predictor and typed rows supply expectations
`timescale 1ns / 100ps

module tb_tagged_decimal_frame_parser;
    import tdfp_pkg::*;

    localparam int     STALL_LIMIT   = 2000;
    localparam int     ITEM_TARGET   = 1300;
    localparam longint VAL_MAX       = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
    localparam longint VAL_MIN       = -VAL_MAX - 1;
    localparam t_byte  CH_PLUS       = 8'h2b;

    // character that closes each field
    localparam t_byte CLOSE_CHAR [FIELD_COUNT] = '{CH_SEP_A, CH_SEP_B, CH_SEP_C, CH_SEP_D, CH_TAIL};
    // space, tab, lf, vt, ff, cr
    localparam t_byte BLANK_CHAR [6] = '{CH_SPACE, CH_TAB, t_byte'(CH_TAB + 1),
        t_byte'(CH_TAB + 2), t_byte'(CH_TAB + 3), CH_CR};

    typedef logic [OUT_DATA_WIDTH-1:0] t_frame;

    typedef struct {
        string  text;
        bit     typed;
        t_frame want;
    } t_row;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_s_axis_tvalid;
    logic   o_s_axis_tready;
    logic   [BYTE_WIDTH-1:0] i_s_axis_tdata;       // [7:0] rx_byte
    logic   o_m_axis_tvalid;
    logic   i_m_axis_tready;
    // [31:0] value_one, [63:32] value_two, [95:64] value_three,
    // [127:96] value_four, [159:128] value_five
    logic   [OUT_DATA_WIDTH-1:0] o_m_axis_tdata;

    // predictor state
    bit     frame_open;
    int     field_pos;
    t_value field_acc;
    bit     field_digits;
    bit     field_closed;
    bit     field_neg;
    t_value held_vals [FIELD_COUNT];

    t_frame pending_frames [$];
    t_row   rows [$];
    int     errors;
    int     idle_cycles;
    int     sent_words;
    bit     quiet_phase;

    tagged_decimal_frame_parser u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_frame pack_values(input t_value v1, input t_value v2,
                                           input t_value v3, input t_value v4,
                                           input t_value v5);
        return {OUT_WIDTH'(v5), OUT_WIDTH'(v4), OUT_WIDTH'(v3), OUT_WIDTH'(v2), OUT_WIDTH'(v1)};
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    task automatic add_row(input string text, input bit typed, input t_frame want);
        t_row row;
        row.text  = text;
        row.typed = typed;
        row.want  = want;
        rows.push_back(row);
    endtask

    // frame parser prediction for one accepted byte; queues the frame it completes
    task automatic parse_byte(input t_byte c, input bit typed, input t_frame want);
        longint nxt;
        t_frame frame;
        if (!frame_open) begin
            if (c == CH_HEAD) begin
                frame_open   = 1'b1;
                field_pos    = 0;
                field_acc    = '0;
                field_digits = 1'b0;
                field_closed = 1'b0;
                field_neg    = 1'b0;
            end
        end else if (c == CH_HEAD) begin
            // a repeated head inside a frame is dropped
        end else if (c == CLOSE_CHAR[field_pos]) begin
            if (field_digits)
                held_vals[field_pos] = field_acc;
            field_acc    = '0;
            field_digits = 1'b0;
            field_closed = 1'b0;
            field_neg    = 1'b0;
            if (field_pos == FIELD_COUNT - 1) begin
                frame_open = 1'b0;
                field_pos  = 0;
                frame = pack_values(held_vals[0], held_vals[1], held_vals[2],
                                    held_vals[3], held_vals[4]);
                pending_frames.push_back(typed ? want : frame);
            end else begin
                field_pos++;
            end
        end else if (c == CH_TAIL) begin
            // tail before the last field abandons the frame
            frame_open   = 1'b0;
            field_pos    = 0;
            field_acc    = '0;
            field_digits = 1'b0;
            field_closed = 1'b0;
            field_neg    = 1'b0;
        end else if (!field_closed) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                field_digits = 1'b1;
                if (field_neg) begin
                    nxt = longint'(field_acc) * 10 - longint'(c - CH_ZERO);
                    if (nxt < VAL_MIN)
                        nxt = VAL_MIN;
                end else begin
                    nxt = longint'(field_acc) * 10 + longint'(c - CH_ZERO);
                    if (nxt > VAL_MAX)
                        nxt = VAL_MAX;
                end
                field_acc = t_value'(nxt);
            end else if (!field_digits && !field_neg
                         && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                // leading blank skipped
            end else if (!field_digits && !field_neg && c == CH_MINUS) begin
                field_neg = 1'b1;
            end else begin
                field_closed = 1'b1;
            end
        end
    endtask

    // offer one word, entered and left at a falling edge
    task automatic send_byte(input t_byte c, input bit typed, input t_frame want);
        int gap;
        quiet_phase = (sent_words % 240) >= 200;
        gap = pick_gap();
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        sent_words++;
        parse_byte(c, typed, want);
        @(negedge i_clk);
    endtask

    // one random frame, mostly well formed, sometimes broken, preceded by noise or replaced by noise alone
    task automatic build_frame(ref t_byte q[$]);
        int r;
        int n;
        q.delete();
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 20)) q.push_back(t_byte'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) q.push_back(t_byte'($urandom_range(0, 255)));
        q.push_back(CH_HEAD);
        for (int k = 0; k < FIELD_COUNT; k++) begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) q.push_back(BLANK_CHAR[$urandom_range(0, 5)]);
            r = $urandom_range(0, 99);
            if (r >= 10) begin
                if ($urandom_range(0, 2) == 0)
                    q.push_back(CH_MINUS);
                n = (r < 22) ? $urandom_range(10, 12) : $urandom_range(1, 5);
                repeat (n) q.push_back(t_byte'(CH_ZERO + $urandom_range(0, 9)));
            end
            // trailing junk inside the field
            if ($urandom_range(0, 6) == 0) begin
                case ($urandom_range(0, 4))
                    0:       q.push_back(CH_MINUS);
                    1:       q.push_back(CH_PLUS);
                    2:       q.push_back(CH_SPACE);
                    3:       q.push_back(CH_HEAD);
                    default: q.push_back(t_byte'($urandom_range(0, 255)));
                endcase
                if ($urandom_range(0, 1) == 0)
                    q.push_back(t_byte'(CH_ZERO + $urandom_range(0, 9)));
            end
            if (k < FIELD_COUNT - 1 && $urandom_range(0, 99) < 3) begin
                q.push_back(CH_TAIL);
                return;
            end
            q.push_back(CLOSE_CHAR[k]);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_frame want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_frames.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, got %h", $time, o_m_axis_tdata);
            end else begin
                want = pending_frames.pop_front();
                for (int i = 0; i < FIELD_COUNT; i++) begin
                    if (want[i*OUT_WIDTH +: OUT_WIDTH]
                        !== o_m_axis_tdata[i*OUT_WIDTH +: OUT_WIDTH]) begin
                        errors++;
                        $display("%0t: value %0d expected %0d got %0d", $time, i + 1,
                                 $signed(want[i*OUT_WIDTH +: OUT_WIDTH]),
                                 $signed(o_m_axis_tdata[i*OUT_WIDTH +: OUT_WIDTH]));
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted word or taken result
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // result side backpressure
    initial begin : drive_ready
        int stall_left;
        stall_left      = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            i_m_axis_tready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // stimulus
    initial begin : run
        t_byte q[$];
        i_rst_n          = 1'b0;
        i_s_axis_tvalid  = 1'b0;
        i_s_axis_tdata   = '0;
        errors           = 0;
        idle_cycles      = 0;
        sent_words       = 0;
        quiet_phase      = 1'b0;
        frame_open       = 1'b0;
        field_pos        = 0;
        field_acc        = '0;
        field_digits     = 1'b0;
        field_closed     = 1'b0;
        field_neg        = 1'b0;
        for (int i = 0; i < FIELD_COUNT; i++)
            held_vals[i] = '0;

        // empty fields right after reset give zeros
        add_row("HabcdT", 1'b1, '0);
        add_row("xyz1-aT", 1'b0, '0);
        add_row("H1a2b3c4d5T", 1'b1, pack_values(1, 2, 3, 4, 5));
        add_row("H2147483647a-2147483648b99999999999c-99999999999d0T", 1'b1,
                pack_values(t_value'(VAL_MAX), t_value'(VAL_MIN), t_value'(VAL_MAX),
                            t_value'(VAL_MIN), 0));
        // tail before the last field, then a frame of empty fields
        add_row("H7a8T", 1'b0, '0);
        add_row("H a\011b c d T", 1'b0, '0);
        // repeated head, minus zero, double minus, plus, bare minus
        add_row("H1H2a-0b--5c+6d-T", 1'b0, '0);
        // wrong separator, inner blank, trailing minus, high byte
        add_row("H1b2a3 4b5-6c\377 9d 0x7T", 1'b0, '0);
        add_row("H\011\012\013\014\015-000042a- 5b-9c9-d12T", 1'b0, '0);
        add_row("H-2147483649a2147483648bcdT", 1'b0, '0);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r])
            for (int i = 0; i < rows[r].text.len(); i++)
                send_byte(rows[r].text[i], rows[r].typed, rows[r].want);

        while (sent_words < ITEM_TARGET) begin
            build_frame(q);
            foreach (q[i])
                send_byte(q[i], 1'b0, '0);
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_frames.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* tagged_decimal_frame_parser.f */
rtl/tdfp_pkg.sv
rtl/tdfp_digit_acc.sv
rtl/tdfp_frame_ctrl.sv
rtl/tagged_decimal_frame_parser.sv
verif/tb_tagged_decimal_frame_parser.sv
